// File: hw/rtl/als_pkg.sv
// als_pkg: shared types, register map and helpers for the arm/launch sequencer
// no dependencies; used by als_regs, als_core and arm_launch_sequencer_unit
package als_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned TickW    = 8;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // register reset values
  localparam logic [TickW-1:0]  TickMsRst       = 8'd33;
  localparam logic [CountW-1:0] ArmHoldMsRst    = 16'd500;
  localparam logic [CountW-1:0] ArmedWaitMsRst  = 16'd2000;
  localparam logic [CountW-1:0] LaunchHoldMsRst = 16'd500;
  localparam logic [CountW-1:0] AbortHoldMsRst  = 16'd100;
  localparam logic [CountW-1:0] AbortWaitMsRst  = 16'd1000;
  localparam logic [CountW-1:0] FireMsRst       = 16'd500;

  // register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_TICK_MS        = 3'd0,
    REG_ARM_HOLD_MS    = 3'd1,
    REG_ARMED_WAIT_MS  = 3'd2,
    REG_LAUNCH_HOLD_MS = 3'd3,
    REG_ABORT_HOLD_MS  = 3'd4,
    REG_ABORT_WAIT_MS  = 3'd5,
    REG_FIRE_MS        = 3'd6
  } reg_idx_t;

  typedef enum logic [PhaseW-1:0] {
    PH_RESET       = 3'd0,
    PH_ARM_WAIT    = 3'd1,
    PH_ARMED       = 3'd2,
    PH_ARMED_DELAY = 3'd3,
    PH_ABORT_DELAY = 3'd4,
    PH_LAUNCH      = 3'd5
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0]  tick_ms;
    logic [CountW-1:0] arm_hold_ms;
    logic [CountW-1:0] armed_wait_ms;
    logic [CountW-1:0] launch_hold_ms;
    logic [CountW-1:0] abort_hold_ms;
    logic [CountW-1:0] abort_wait_ms;
    logic [CountW-1:0] fire_ms;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [CountW-1:0] hold_count;
    logic [CountW-1:0] abort_count;
    logic              led;
    logic              valve;
  } seq_state_t;

  // saturating add of one tick to a count
  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] count,
                                                input logic [TickW-1:0]  tick);
    logic [CountW:0] sum;
    sum = {1'b0, count} + {{(CountW+1-TickW){1'b0}}, tick};
    return sum[CountW] ? CountMax : sum[CountW-1:0];
  endfunction

endpackage

// File: hw/rtl/als_regs.sv
// als_regs: APB-style configuration register file for the sequencer timings
// depends on als_pkg
module als_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [als_pkg::AddrW-1:0]  paddr,
  input  logic [als_pkg::DataW-1:0]  pwdata,
  output logic [als_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output als_pkg::cfg_t              cfg
);

  logic              wr_en;
  als_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = als_pkg::reg_idx_t'(paddr[als_pkg::AddrW-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_ms        <= als_pkg::TickMsRst;
      cfg.arm_hold_ms    <= als_pkg::ArmHoldMsRst;
      cfg.armed_wait_ms  <= als_pkg::ArmedWaitMsRst;
      cfg.launch_hold_ms <= als_pkg::LaunchHoldMsRst;
      cfg.abort_hold_ms  <= als_pkg::AbortHoldMsRst;
      cfg.abort_wait_ms  <= als_pkg::AbortWaitMsRst;
      cfg.fire_ms        <= als_pkg::FireMsRst;
    end else if (wr_en) begin
      case (idx)
        als_pkg::REG_TICK_MS:        cfg.tick_ms        <= pwdata[als_pkg::TickW-1:0];
        als_pkg::REG_ARM_HOLD_MS:    cfg.arm_hold_ms    <= pwdata[als_pkg::CountW-1:0];
        als_pkg::REG_ARMED_WAIT_MS:  cfg.armed_wait_ms  <= pwdata[als_pkg::CountW-1:0];
        als_pkg::REG_LAUNCH_HOLD_MS: cfg.launch_hold_ms <= pwdata[als_pkg::CountW-1:0];
        als_pkg::REG_ABORT_HOLD_MS:  cfg.abort_hold_ms  <= pwdata[als_pkg::CountW-1:0];
        als_pkg::REG_ABORT_WAIT_MS:  cfg.abort_wait_ms  <= pwdata[als_pkg::CountW-1:0];
        als_pkg::REG_FIRE_MS:        cfg.fire_ms        <= pwdata[als_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      als_pkg::REG_TICK_MS:
        prdata = {{(als_pkg::DataW-als_pkg::TickW){1'b0}}, cfg.tick_ms};
      als_pkg::REG_ARM_HOLD_MS:
        prdata = {{(als_pkg::DataW-als_pkg::CountW){1'b0}}, cfg.arm_hold_ms};
      als_pkg::REG_ARMED_WAIT_MS:
        prdata = {{(als_pkg::DataW-als_pkg::CountW){1'b0}}, cfg.armed_wait_ms};
      als_pkg::REG_LAUNCH_HOLD_MS:
        prdata = {{(als_pkg::DataW-als_pkg::CountW){1'b0}}, cfg.launch_hold_ms};
      als_pkg::REG_ABORT_HOLD_MS:
        prdata = {{(als_pkg::DataW-als_pkg::CountW){1'b0}}, cfg.abort_hold_ms};
      als_pkg::REG_ABORT_WAIT_MS:
        prdata = {{(als_pkg::DataW-als_pkg::CountW){1'b0}}, cfg.abort_wait_ms};
      als_pkg::REG_FIRE_MS:
        prdata = {{(als_pkg::DataW-als_pkg::CountW){1'b0}}, cfg.fire_ms};
      default:
        prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/als_core.sv
// als_core: sequencer state registers and per-tick next-state logic
// depends on als_pkg
module als_core (
  input  logic                 clk,
  input  logic                 rst,
  input  als_pkg::cfg_t        cfg,
  input  logic                 step,
  input  logic                 arm_level,
  input  logic                 launch_level,
  output als_pkg::seq_state_t  state_next
);

  als_pkg::seq_state_t state;
  logic                arm_pressed;
  logic                launch_pressed;
  logic [als_pkg::CountW-1:0] hold_inc;
  logic [als_pkg::CountW-1:0] abort_inc;

  assign arm_pressed    = ~arm_level;
  assign launch_pressed = ~launch_level;
  assign hold_inc       = als_pkg::sat_add(state.hold_count, cfg.tick_ms);
  assign abort_inc      = als_pkg::sat_add(state.abort_count, cfg.tick_ms);

  // state register, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= als_pkg::PH_RESET;
      state.hold_count  <= '0;
      state.abort_count <= '0;
      state.led         <= 1'b0;
      state.valve       <= 1'b0;
    end else if (step) begin
      state <= state_next;
    end
  end

  // next state for one tick
  always_comb begin
    state_next = state;
    case (state.phase)
      als_pkg::PH_RESET: begin
        state_next.phase       = als_pkg::PH_ARM_WAIT;
        state_next.hold_count  = '0;
        state_next.abort_count = '0;
        state_next.led         = 1'b0;
        state_next.valve       = 1'b0;
      end
      als_pkg::PH_ARM_WAIT: begin
        if (state.hold_count >= cfg.arm_hold_ms) begin
          state_next.phase       = als_pkg::PH_ARMED_DELAY;
          state_next.hold_count  = '0;
          state_next.abort_count = '0;
        end else begin
          state_next.hold_count = arm_pressed ? hold_inc : '0;
        end
      end
      als_pkg::PH_ARMED_DELAY: begin
        state_next.led = 1'b1;
        if (state.hold_count >= cfg.armed_wait_ms) begin
          state_next.phase       = als_pkg::PH_ARMED;
          state_next.hold_count  = '0;
          state_next.abort_count = '0;
        end else begin
          state_next.hold_count = hold_inc;
        end
      end
      als_pkg::PH_ARMED: begin
        // launch wins when both holds complete together
        if (state.hold_count >= cfg.launch_hold_ms) begin
          state_next.phase       = als_pkg::PH_LAUNCH;
          state_next.hold_count  = '0;
          state_next.abort_count = '0;
        end else if (state.abort_count >= cfg.abort_hold_ms) begin
          state_next.phase       = als_pkg::PH_ABORT_DELAY;
          state_next.hold_count  = '0;
          state_next.abort_count = '0;
        end else begin
          state_next.hold_count  = launch_pressed ? hold_inc : '0;
          state_next.abort_count = arm_pressed ? abort_inc : '0;
        end
      end
      als_pkg::PH_ABORT_DELAY: begin
        state_next.led = 1'b0;
        if (state.hold_count >= cfg.abort_wait_ms) begin
          state_next.phase = als_pkg::PH_RESET;
        end else begin
          state_next.hold_count = hold_inc;
        end
      end
      als_pkg::PH_LAUNCH: begin
        state_next.valve = 1'b1;
        if (state.hold_count >= cfg.fire_ms) begin
          state_next.phase = als_pkg::PH_RESET;
        end else begin
          state_next.hold_count = hold_inc;
        end
      end
      default: begin
        state_next.phase = als_pkg::PH_RESET;
      end
    endcase
  end

endmodule

// File: hw/rtl/arm_launch_sequencer_unit.sv
// arm_launch_sequencer_unit: top level of the arm/launch sequencer
// depends on als_pkg, als_regs, als_core
//
//   channel   direction  signals                                   role
//   tick in   input      in_valid/in_ready, arm_level, launch_level one timer tick
//   result    output     out_valid/out_ready, led_on, valve_on, phase drive after tick
//   config    apb        psel/penable/pwrite/paddr/pwdata/prdata   timing registers
//
// an accepted tick is held in the input register, then the sequencer next-state
// logic loads the result register, where its result is presented; one tick per
// cycle sustained while out_ready does not stall the result stage.
// the sequencer state advances as a tick moves from the input register into the
// result register, which is the only serial dependency between ticks.
// synchronous active-high rst clears control state and restores register defaults.
// a stalled result holds both stages; in_ready stays high while the input stage can drain.
module arm_launch_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              arm_level,
  input  logic                              launch_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              led_on,
  output logic                              valve_on,
  output logic [als_pkg::PhaseW-1:0]        phase,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [als_pkg::AddrW-1:0]         paddr,
  input  logic [als_pkg::DataW-1:0]         pwdata,
  output logic [als_pkg::DataW-1:0]         prdata,
  output logic                              pready
);

  als_pkg::cfg_t       cfg;
  als_pkg::seq_state_t state_next;
  logic                stage_valid;
  logic                stage_arm;
  logic                stage_launch;
  logic                out_free;
  logic                step;

  assign out_free = !out_valid || out_ready;
  assign step     = stage_valid && out_free;
  assign in_ready = !stage_valid || out_free;

  als_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  als_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .step         (step),
    .arm_level    (stage_arm),
    .launch_level (stage_launch),
    .state_next   (state_next)
  );

  // input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_arm    <= arm_level;
      stage_launch <= launch_level;
    end
  end

  // result stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (step) begin
      led_on   <= state_next.led;
      valve_on <= state_next.valve;
      phase    <= state_next.phase;
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// testbench for arm_launch_sequencer_unit: timer ticks go in over valid/ready with random
// stalls on both sides, and each result is checked against a local sequencer model
// depends on als_pkg and the arm_launch_sequencer_unit rtl
module testbench;

  localparam int WatchdogLimit = 2000;
  localparam int UnusedRegIdx  = 7;
  localparam int MaxRunTicks   = 300;

  // how a well-formed arming cycle ends while armed
  typedef enum int {
    END_LAUNCH,
    END_ABORT,
    END_BOTH
  } cycle_end_t;

  typedef struct {
    logic arm;
    logic launch;
  } tick_item_t;

  typedef struct {
    logic                       led;
    logic                       valve;
    logic [als_pkg::PhaseW-1:0] phase;
  } drive_t;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic                       arm_level    = 1'b1;
  logic                       launch_level = 1'b1;
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic                       led_on;
  logic                       valve_on;
  logic [als_pkg::PhaseW-1:0] phase;
  logic                       psel         = 1'b0;
  logic                       penable      = 1'b0;
  logic                       pwrite       = 1'b0;
  logic [als_pkg::AddrW-1:0]  paddr        = '0;
  logic [als_pkg::DataW-1:0]  pwdata       = '0;
  logic [als_pkg::DataW-1:0]  prdata;
  logic                       pready;

  arm_launch_sequencer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .arm_level    (arm_level),
    .launch_level (launch_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .led_on       (led_on),
    .valve_on     (valve_on),
    .phase        (phase),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // sequencer model state and timing shadow
  als_pkg::cfg_t              timing;
  als_pkg::phase_t            seq_phase;
  logic [als_pkg::CountW-1:0] seq_hold;
  logic [als_pkg::CountW-1:0] seq_abort;
  logic                       seq_led;
  logic                       seq_valve;

  tick_item_t tick_queue[$];
  drive_t     predicted_drive[$];
  int         planned_ticks;
  int         mismatch_count;
  bit         idle_on;
  bit         tick_taken;
  int         in_gap;
  int         out_stall;
  int         quiet_cycles;

  // one tick added to a count, held at full scale
  function automatic logic [als_pkg::CountW-1:0] bump(input logic [als_pkg::CountW-1:0] count);
    logic [als_pkg::CountW:0] total;
    total = {1'b0, count}
          + {{(als_pkg::CountW+1-als_pkg::TickW){1'b0}}, timing.tick_ms};
    return total[als_pkg::CountW] ? '1 : total[als_pkg::CountW-1:0];
  endfunction

  function automatic void enter_phase(input als_pkg::phase_t next);
    seq_phase = next;
    seq_hold  = '0;
    seq_abort = '0;
  endfunction

  // advance the model by one tick and return the drive it leaves
  function automatic drive_t sequencer_step(input logic arm_lvl, input logic launch_lvl);
    logic   arm_down;
    logic   launch_down;
    drive_t r;
    arm_down    = !arm_lvl;
    launch_down = !launch_lvl;
    case (seq_phase)
      als_pkg::PH_RESET: begin
        enter_phase(als_pkg::PH_ARM_WAIT);
        seq_led   = 1'b0;
        seq_valve = 1'b0;
      end
      als_pkg::PH_ARM_WAIT: begin
        if (seq_hold >= timing.arm_hold_ms) enter_phase(als_pkg::PH_ARMED_DELAY);
        else seq_hold = arm_down ? bump(seq_hold) : '0;
      end
      als_pkg::PH_ARMED_DELAY: begin
        seq_led = 1'b1;
        if (seq_hold >= timing.armed_wait_ms) enter_phase(als_pkg::PH_ARMED);
        else seq_hold = bump(seq_hold);
      end
      als_pkg::PH_ARMED: begin
        // a completed launch hold beats a completed abort hold
        if (seq_hold >= timing.launch_hold_ms) begin
          enter_phase(als_pkg::PH_LAUNCH);
        end else if (seq_abort >= timing.abort_hold_ms) begin
          enter_phase(als_pkg::PH_ABORT_DELAY);
        end else begin
          seq_hold  = launch_down ? bump(seq_hold) : '0;
          seq_abort = arm_down ? bump(seq_abort) : '0;
        end
      end
      als_pkg::PH_ABORT_DELAY: begin
        seq_led = 1'b0;
        if (seq_hold >= timing.abort_wait_ms) seq_phase = als_pkg::PH_RESET;
        else seq_hold = bump(seq_hold);
      end
      als_pkg::PH_LAUNCH: begin
        seq_valve = 1'b1;
        if (seq_hold >= timing.fire_ms) seq_phase = als_pkg::PH_RESET;
        else seq_hold = bump(seq_hold);
      end
      default: seq_phase = als_pkg::PH_RESET;
    endcase
    r.led   = seq_led;
    r.valve = seq_valve;
    r.phase = seq_phase;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // stimulus builders
  task automatic add_ticks(input logic arm, input logic launch, input int n);
    tick_item_t t;
    t.arm    = arm;
    t.launch = launch;
    repeat (n) begin
      tick_queue.push_back(t);
      planned_ticks++;
    end
  endtask

  task automatic add_noise(input int n);
    tick_item_t t;
    repeat (n) begin
      t.arm    = $urandom_range(0, 1);
      t.launch = $urandom_range(0, 1);
      tick_queue.push_back(t);
      planned_ticks++;
    end
  endtask

  // ticks a held button needs before the phase sees the threshold reached
  function automatic int ticks_for(input logic [als_pkg::CountW-1:0] thr);
    int n;
    if (thr == 0) return 1;
    if (timing.tick_ms == 0) return 6;
    n = (int'(thr) + int'(timing.tick_ms) - 1) / int'(timing.tick_ms) + 1;
    return (n > MaxRunTicks) ? MaxRunTicks : n;
  endfunction

  // arm, wait out the delay, then launch or abort; some cycles are cut short
  task automatic add_launch_cycle();
    bit         broken;
    cycle_end_t ending;
    int         n;
    broken = ($urandom_range(0, 4) == 0);
    add_ticks(1'b1, 1'b1, $urandom_range(1, 3));
    n = ticks_for(timing.arm_hold_ms) + $urandom_range(0, 2);
    if (broken) n = $urandom_range(0, n);
    add_ticks(1'b0, 1'b1, n);
    add_noise(ticks_for(timing.armed_wait_ms) + 1);
    ending = cycle_end_t'($urandom_range(0, 2));
    n = ticks_for(timing.launch_hold_ms);
    if (ticks_for(timing.abort_hold_ms) > n) n = ticks_for(timing.abort_hold_ms);
    n = n + 1;
    if (broken) n = $urandom_range(0, n);
    add_ticks(ending == END_LAUNCH, ending == END_ABORT, n);
    n = ticks_for(timing.fire_ms);
    if (ticks_for(timing.abort_wait_ms) > n) n = ticks_for(timing.abort_wait_ms);
    n = n + 2;
    if (broken) add_noise(n);
    else add_ticks(1'b1, 1'b1, n);
  endtask

  task automatic add_cycles(input int count);
    int start;
    start = planned_ticks;
    while (planned_ticks - start < count) begin
      if ($urandom_range(0, 5) == 0) add_noise($urandom_range(1, 10));
      add_launch_cycle();
    end
  endtask

  // register access, only while the sequencer is idle
  task automatic write_reg(input int idx, input logic [als_pkg::DataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= als_pkg::AddrW'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      als_pkg::REG_TICK_MS:
        timing.tick_ms        = value[als_pkg::TickW-1:0];
      als_pkg::REG_ARM_HOLD_MS:
        timing.arm_hold_ms    = value[als_pkg::CountW-1:0];
      als_pkg::REG_ARMED_WAIT_MS:
        timing.armed_wait_ms  = value[als_pkg::CountW-1:0];
      als_pkg::REG_LAUNCH_HOLD_MS:
        timing.launch_hold_ms = value[als_pkg::CountW-1:0];
      als_pkg::REG_ABORT_HOLD_MS:
        timing.abort_hold_ms  = value[als_pkg::CountW-1:0];
      als_pkg::REG_ABORT_WAIT_MS:
        timing.abort_wait_ms  = value[als_pkg::CountW-1:0];
      als_pkg::REG_FIRE_MS:
        timing.fire_ms        = value[als_pkg::CountW-1:0];
      default: ;
    endcase
  endtask

  // write all timing registers, with junk in the bits above each field
  task automatic program_timing(input int tick, input int arm, input int delay,
                                input int launch, input int abort_h, input int abort_d,
                                input int fire);
    logic [als_pkg::DataW-1:0] junk;
    junk = $urandom;
    write_reg(als_pkg::REG_TICK_MS,        {junk[31:8], 8'(tick)});
    write_reg(als_pkg::REG_ARM_HOLD_MS,    {junk[15:0], 16'(arm)});
    write_reg(als_pkg::REG_ARMED_WAIT_MS,  {junk[31:16], 16'(delay)});
    write_reg(als_pkg::REG_LAUNCH_HOLD_MS, {junk[15:0], 16'(launch)});
    write_reg(als_pkg::REG_ABORT_HOLD_MS,  {junk[31:16], 16'(abort_h)});
    write_reg(als_pkg::REG_ABORT_WAIT_MS,  {junk[15:0], 16'(abort_d)});
    write_reg(als_pkg::REG_FIRE_MS,        {junk[31:16], 16'(fire)});
    @(posedge clk);
  endtask

  // hold off until every tick is through and the pipeline has emptied
  task automatic settle();
    while (tick_queue.size() != 0 || in_valid || predicted_drive.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // tick driver
  always @(negedge clk) begin
    tick_item_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tick_taken) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        t = tick_queue.pop_front();
        in_valid     <= 1'b1;
        arm_level    <= t.arm;
        launch_level <= t.launch;
        if (idle_on && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check, then prediction for the tick taken at this edge
  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      tick_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_drive.size() == 0) begin
          report_mismatch($sformatf("result with no tick outstanding, phase %0d", phase));
        end else begin
          want = predicted_drive.pop_front();
          if (led_on !== want.led)
            report_mismatch($sformatf("led_on mismatch: got %0b want %0b", led_on, want.led));
          if (valve_on !== want.valve)
            report_mismatch($sformatf("valve_on mismatch: got %0b want %0b",
                                      valve_on, want.valve));
          if (phase !== want.phase)
            report_mismatch($sformatf("phase mismatch: got %0d want %0d", phase, want.phase));
        end
      end
      if (in_valid && in_ready) predicted_drive.push_back(sequencer_step(arm_level, launch_level));
      tick_taken <= in_valid && in_ready;
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    timing.tick_ms        = als_pkg::TickMsRst;
    timing.arm_hold_ms    = als_pkg::ArmHoldMsRst;
    timing.armed_wait_ms  = als_pkg::ArmedWaitMsRst;
    timing.launch_hold_ms = als_pkg::LaunchHoldMsRst;
    timing.abort_hold_ms  = als_pkg::AbortHoldMsRst;
    timing.abort_wait_ms  = als_pkg::AbortWaitMsRst;
    timing.fire_ms        = als_pkg::FireMsRst;
    seq_phase      = als_pkg::PH_RESET;
    seq_hold       = '0;
    seq_abort      = '0;
    seq_led        = 1'b0;
    seq_valve      = 1'b0;
    planned_ticks  = 0;
    mismatch_count = 0;
    idle_on        = 1'b1;
    in_gap         = 0;
    out_stall      = 0;
    quiet_cycles   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every button combination at the reset timing
    add_ticks(1'b1, 1'b1, 1);
    add_ticks(1'b0, 1'b0, 1);
    add_ticks(1'b0, 1'b1, 1);
    add_ticks(1'b1, 1'b0, 1);
    settle();

    // slowest tick, short thresholds; an out-of-map write must change nothing
    write_reg(UnusedRegIdx, $urandom);
    program_timing(1, 2, 1, 2, 2, 1, 1);
    // released arm clears its hold, then arm and fire with launch and abort held together
    add_ticks(1'b0, 1'b1, 1);
    add_ticks(1'b1, 1'b1, 1);
    add_ticks(1'b0, 1'b1, 3);
    add_ticks(1'b1, 1'b1, 2);
    add_ticks(1'b0, 1'b0, 3);
    add_ticks(1'b1, 1'b1, 3);
    // arm, then abort by holding arm again
    add_ticks(1'b0, 1'b1, 3);
    add_ticks(1'b1, 1'b1, 2);
    add_ticks(1'b0, 1'b1, 3);
    add_ticks(1'b1, 1'b1, 3);
    settle();

    // fast tick against a full-scale arm hold, so the count saturates before it arms
    program_timing(254, 65535, 0, 0, 0, 0, 0);
    add_cycles(250);
    settle();

    // zero tick: only zero thresholds ever complete
    program_timing(0, 0, 0, 3, 0, 0, 0);
    add_cycles(40);
    settle();

    // back to the reset timing
    program_timing(als_pkg::TickMsRst, als_pkg::ArmHoldMsRst, als_pkg::ArmedWaitMsRst,
                   als_pkg::LaunchHoldMsRst, als_pkg::AbortHoldMsRst,
                   als_pkg::AbortWaitMsRst, als_pkg::FireMsRst);
    add_cycles(130);
    settle();

    // all thresholds zero, every timed phase lasts one tick
    program_timing(255, 0, 0, 0, 0, 0, 0);
    add_cycles(40);
    settle();

    // random timing
    repeat (2) begin
      program_timing($urandom_range(4, 40), $urandom_range(0, 120), $urandom_range(0, 120),
                     $urandom_range(0, 120), $urandom_range(0, 120), $urandom_range(0, 120),
                     $urandom_range(0, 120));
      add_cycles(70);
      settle();
    end

    // closing stretch at full rate with no stalls
    idle_on = 1'b0;
    program_timing(1, 3, 2, 4, 3, 2, 3);
    add_cycles(120);
    settle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
